// ----- hw/rtl/tlbw_pkg.sv -----
// shared types and constants for the task leaky-bucket watchdog
package tlbw_pkg;

	// field widths
	localparam int COUNT_W   = 16;
	localparam int CREDIT_W  = 3;
	localparam int OP_W      = 2;
	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;

	// bucket fill after reset and credits added by a pet
	localparam logic [CREDIT_W-1:0] CREDIT_RESET = 3'd5;
	localparam logic [CREDIT_W-1:0] PET_CREDITS  = 3'd2;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_ZERO  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_ONE   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CREDIT_LIMIT = 2'd2;

	// register reset values
	localparam logic [COUNT_W-1:0]  PERIOD_ZERO_RESET = 16'd100;
	localparam logic [COUNT_W-1:0]  PERIOD_ONE_RESET  = 16'd1000;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 2'd0,
		OP_PET    = 2'd1,
		OP_EXPIRE = 2'd2
	} op_t;

	// one per-task memory entry
	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [CREDIT_W-1:0] credits;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{count: '0, credits: CREDIT_RESET};

endpackage

// ----- hw/rtl/task_leaky_bucket_watchdog_unit.sv -----
// top level of the per-task leaky-bucket watchdog
//
// Input stream s_axis carries one operation per transaction: tick, pet or
// mark-expired, aimed at one task. Each input transaction yields exactly one
// output transaction on m_axis with the addressed task's timeout status and
// the global expired latch.
// The per-task tick counter and credit bucket live in a small synchronous
// memory. An accepted item reads its entry in the accept cycle into stage 1,
// which modifies the entry, writes it back and loads the output register
// once that register is free. s_axis_tready drops while an entry is in its
// read-modify-write, so no new item is taken before the last one leaves
// stage 1; this keeps reads and writes of one entry apart.
// When the receiver stalls, a finished result waits in the output register
// while the next item is accepted and read; that item then holds until the
// output register frees up.
// Reset clears per-entry valid bits, so every entry reads as count zero and
// a full bucket of five credits until first written; the periods and credit
// limit return to 100, 1000 and 5. No clearing pass is needed.
// Configuration is written through wr_en/wr_index/wr_data; the user must do
// so only while idle, as the block itself does not enforce it.
module task_leaky_bucket_watchdog_unit #(
	parameter int TASK_COUNT = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [1:0] operation, [2] task_index, [7:3] zero
	input  logic [tlbw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// output stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] timed_out, [1] expired_flag, [2] expired_id, [7:3] zero
	output logic [tlbw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// configuration write port
	input  logic                             wr_en,
	input  logic [tlbw_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [tlbw_pkg::CFG_W-1:0]       wr_data
);
	import tlbw_pkg::*;

	localparam int AW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

	// configuration registers
	logic [COUNT_W-1:0]  period_zero_q;
	logic [COUNT_W-1:0]  period_one_q;
	logic [CREDIT_W-1:0] credit_limit_q;

	// entry memory and its valid bits
	entry_t              mem [TASK_COUNT];
	logic [TASK_COUNT-1:0] entry_vld_q;

	// stage 1 item under read-modify-write
	logic                valid_s1;
	op_t                 op_s1;
	logic [AW-1:0]       addr_s1;
	logic                in_range_s1;
	entry_t              rd_entry_s1;
	logic                rd_vld_s1;

	// global expired latch
	logic                expired_flag_q;
	logic                expired_id_q;

	// output register
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic                in_acc;
	logic                in_range;
	logic [AW-1:0]       rd_addr;
	logic                done;
	entry_t              cur_entry;
	entry_t              nxt_entry;
	logic                upd_timed;
	logic [COUNT_W-1:0]  period_sel;
	logic                exp_flag_nxt;
	logic                exp_task_nxt;

	// input handshake: one item in the read-modify-write at a time
	assign s_axis_tready = !valid_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_range      = int'(s_axis_tdata[2]) < TASK_COUNT;
	assign rd_addr       = in_range ? AW'(s_axis_tdata[2]) : '0;

	// stage 1 finishes when the output register can take its result
	assign done = valid_s1 && (!out_valid_q || m_axis_tready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_zero_q  <= PERIOD_ZERO_RESET;
			period_one_q   <= PERIOD_ONE_RESET;
			credit_limit_q <= CREDIT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_PERIOD_ZERO:  period_zero_q  <= wr_data;
				REG_PERIOD_ONE:   period_one_q   <= wr_data;
				REG_CREDIT_LIMIT: credit_limit_q <= wr_data[CREDIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// memory read port, registered data
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_entry_s1 <= mem[rd_addr];
			rd_vld_s1   <= entry_vld_q[rd_addr];
			op_s1       <= op_t'(s_axis_tdata[1:0]);
			addr_s1     <= rd_addr;
			in_range_s1 <= in_range;
		end
	end

	// memory write port
	always_ff @(posedge clk) begin
		if (done && in_range_s1) begin
			mem[addr_s1] <= nxt_entry;
		end
	end

	// stage valid and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			entry_vld_q <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done && in_range_s1) begin
				entry_vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	// never-written entries read as the reset fill
	assign cur_entry  = rd_vld_s1 ? rd_entry_s1 : ENTRY_RESET;
	assign period_sel = (addr_s1 == '0) ? period_zero_q : period_one_q;

	tlbw_update u_update (
		.cur       (cur_entry),
		.op        (op_s1),
		.period    (period_sel),
		.limit     (credit_limit_q),
		.nxt       (nxt_entry),
		.timed_out (upd_timed)
	);

	// expired latch update
	always_comb begin
		exp_flag_nxt = expired_flag_q;
		exp_task_nxt = expired_id_q;
		if (in_range_s1 && op_s1 == OP_EXPIRE) begin
			exp_flag_nxt = 1'b1;
			exp_task_nxt = addr_s1[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expired_flag_q <= 1'b0;
			expired_id_q   <= 1'b0;
		end else if (done) begin
			expired_flag_q <= exp_flag_nxt;
			expired_id_q   <= exp_task_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_data_q <= {(OUT_DATA_W - 3)'(0), exp_task_nxt, exp_flag_nxt,
				in_range_s1 && upd_timed};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- hw/rtl/tlbw_update.sv -----
// next-state logic for one task entry: tick, pet and credit saturation
module tlbw_update (
	input  tlbw_pkg::entry_t               cur,
	input  tlbw_pkg::op_t                  op,
	input  logic [tlbw_pkg::COUNT_W-1:0]   period,
	input  logic [tlbw_pkg::CREDIT_W-1:0]  limit,
	output tlbw_pkg::entry_t               nxt,
	output logic                           timed_out
);
	import tlbw_pkg::*;

	logic [COUNT_W-1:0]  count_inc;
	logic [CREDIT_W:0]   pet_sum;

	assign count_inc = cur.count + COUNT_W'(1);
	assign pet_sum   = {1'b0, cur.credits} + {1'b0, PET_CREDITS};

	// per-operation update of counter and bucket
	always_comb begin
		nxt = cur;
		case (op)
			OP_TICK: begin
				if (count_inc > period) begin
					nxt.count = '0;
					if (cur.credits != '0) begin
						nxt.credits = cur.credits - CREDIT_W'(1);
					end
				end else begin
					nxt.count = count_inc;
				end
			end
			OP_PET: begin
				if (pet_sum > {1'b0, limit}) begin
					nxt.credits = limit;
				end else begin
					nxt.credits = pet_sum[CREDIT_W-1:0];
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign timed_out = (nxt.credits == '0);

endmodule

// ----- hw/rtl/tlbw_checker.sv -----
// port-level checks for the task leaky-bucket watchdog, bound to the top level
module tlbw_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [tlbw_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import tlbw_pkg::*;

	logic seen_expired_q;

	// remember an expired flag once it was delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_expired_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[1]) begin
			seen_expired_q <= 1'b1;
		end
	end

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// the entry interlock closes right after an accepted transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted during read-modify-write");

	// the expired latch never clears once reported
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && seen_expired_q |-> m_axis_tdata[1])
		else $error("expired flag dropped");

	// no expired task or padding bit is reported before any task expired
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[1] |-> !m_axis_tdata[2]
			&& m_axis_tdata[OUT_DATA_W-1:3] == '0)
		else $error("expired task or padding set without expiry");

endmodule

bind task_leaky_bucket_watchdog_unit tlbw_checker u_tlbw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- sim/tb_task_leaky_bucket_watchdog_unit.sv -----
// self-checking testbench for the task leaky-bucket watchdog unit
module tb_task_leaky_bucket_watchdog_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import tlbw_pkg::*;

	localparam int TASK_COUNT = 2;
	localparam int CYCLE_LIMIT = 300000;
	localparam int STALL_CYCLES = 300;
	localparam int IDLE_PCT = 32;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// one result as it appears in m_axis_tdata[2:0]
	typedef struct packed {
		logic expired_id;
		logic expired_flag;
		logic timed_out;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;

	// shared test controls
	logic idle_on = 1'b1;
	int stall_orders = 0;
	int stall_seen = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int fail_count = 0;
	int ops_sent = 0;
	int verdicts_checked = 0;
	int timeouts_seen = 0;
	int settings_used = 0;

	// watchdog mirror: configuration and per-task state
	logic [COUNT_W-1:0] period_of [TASK_COUNT];
	logic [CREDIT_W-1:0] credit_cap;
	logic [COUNT_W-1:0] tick_count [TASK_COUNT];
	logic [CREDIT_W-1:0] bucket [TASK_COUNT];
	logic expired_latch;
	logic expired_which;

	verdict_t pending_verdicts [$];

	task_leaky_bucket_watchdog_unit #(
		.TASK_COUNT(TASK_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_verdicts.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// mirror of the watchdog at power-up
	function automatic void clear_mirror();
		period_of[0] = PERIOD_ZERO_RESET;
		period_of[1] = PERIOD_ONE_RESET;
		credit_cap = CREDIT_RESET;
		for (int i = 0; i < TASK_COUNT; i++) begin
			tick_count[i] = '0;
			bucket[i] = CREDIT_RESET;
		end
		expired_latch = 1'b0;
		expired_which = 1'b0;
	endfunction

	// apply one operation to the mirror and return the status it reports
	function automatic verdict_t predict_verdict(input logic [OP_W-1:0] op, input logic task_sel);
		logic [COUNT_W-1:0] next_count;
		logic [CREDIT_W:0] filled;
		verdict_t v;
		v.timed_out = 1'b0;
		if (int'(task_sel) < TASK_COUNT) begin
			case (op)
				OP_TICK: begin
					next_count = tick_count[task_sel] + COUNT_W'(1);
					// period exceeded: drop one credit, never below zero
					if (next_count > period_of[task_sel]) begin
						if (bucket[task_sel] != '0)
							bucket[task_sel] = bucket[task_sel] - CREDIT_W'(1);
						next_count = '0;
					end
					tick_count[task_sel] = next_count;
				end
				OP_PET: begin
					filled = {1'b0, bucket[task_sel]} + {1'b0, PET_CREDITS};
					if (filled > {1'b0, credit_cap})
						filled = {1'b0, credit_cap};
					bucket[task_sel] = filled[CREDIT_W-1:0];
				end
				OP_EXPIRE: begin
					expired_latch = 1'b1;
					expired_which = task_sel;
				end
				default: begin
				end
			endcase
			v.timed_out = (bucket[task_sel] == '0);
		end
		v.expired_flag = expired_latch;
		v.expired_id = expired_which;
		return v;
	endfunction

	// offer one operation and record its predicted status once accepted
	task automatic send_op(input logic [OP_W-1:0] op, input logic task_sel);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_DATA_W-OP_W-1){1'b0}}, task_sel, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_verdicts.push_back(predict_verdict(op, task_sel));
		ops_sent++;
	endtask

	// stop offering and wait until every status has come back
	task automatic await_results();
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one register write while the block is idle
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_PERIOD_ZERO: period_of[0] = value;
			REG_PERIOD_ONE: period_of[1] = value;
			REG_CREDIT_LIMIT: credit_cap = value[CREDIT_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic write_settings(input logic [CFG_W-1:0] p0, input logic [CFG_W-1:0] p1,
			input logic [CREDIT_W-1:0] cap);
		write_reg(REG_PERIOD_ZERO, p0);
		write_reg(REG_PERIOD_ONE, p1);
		write_reg(REG_CREDIT_LIMIT, {{(CFG_W-CREDIT_W){1'b0}}, cap});
		settings_used++;
	endtask

	// output side: check each transaction against the oldest prediction
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = verdict_t'(m_axis_tdata[2:0]);
			if (pending_verdicts.size() == 0) begin
				$error("result with no pending operation: tdata %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_checked++;
				if (got.timed_out) timeouts_seen++;
				if (got.timed_out !== want.timed_out) begin
					$error("timed_out expected %0b actual %0b", want.timed_out, got.timed_out);
					fail_count++;
				end
				if (got.expired_flag !== want.expired_flag) begin
					$error("expired_flag expected %0b actual %0b", want.expired_flag,
						got.expired_flag);
					fail_count++;
				end
				if (got.expired_id !== want.expired_id) begin
					$error("expired_id expected %0b actual %0b", want.expired_id,
						got.expired_id);
					fail_count++;
				end
			end
		end
	end

	// receiver ready: long hold-off on request, else random stalls, or always ready with idling off
	always @(posedge clk) begin
		if (stall_orders != stall_seen) begin
			stall_seen <= stall_orders;
			hold_left <= STALL_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on) begin
			m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// reset values, unused code, a pet on a full bucket and one tick
	task automatic test_reset_values();
		send_op(OP_UNUSED, 1'b0);
		send_op(OP_UNUSED, 1'b1);
		send_op(OP_PET, 1'b0);
		send_op(OP_TICK, 1'b1);
		await_results();
	endtask

	// every operation, draining a bucket past empty and a period that never expires
	task automatic test_operations();
		write_settings(16'd0, 16'hFFFF, 3'd7);
		send_op(OP_PET, 1'b0);
		repeat (8) send_op(OP_TICK, 1'b0);
		send_op(OP_PET, 1'b0);
		repeat (2) send_op(OP_TICK, 1'b1);
		send_op(OP_EXPIRE, 1'b1);
		send_op(OP_EXPIRE, 1'b0);
		send_op(OP_UNUSED, 1'b1);
		await_results();
	endtask

	// zero credit limit, then a limit lowered below the current bucket fill
	task automatic test_limit_edges();
		write_settings(16'd0, 16'd1, 3'd0);
		send_op(OP_PET, 1'b1);
		send_op(OP_PET, 1'b0);
		await_results();
		write_reg(REG_CREDIT_LIMIT, 16'd7);
		repeat (3) send_op(OP_PET, 1'b0);
		await_results();
		write_reg(REG_CREDIT_LIMIT, 16'd2);
		send_op(OP_TICK, 1'b0);
		send_op(OP_PET, 1'b0);
		await_results();
	endtask

	function automatic logic [CFG_W-1:0] pick_period();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'hFFFE;
			3: return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(6));
		endcase
	endfunction

	// random operations over many settings
	task automatic test_random_traffic(input int phases, input int per_phase);
		logic [CFG_W-1:0] p0;
		logic [CFG_W-1:0] p1;
		logic [CREDIT_W-1:0] cap;
		int roll;
		for (int ph = 0; ph < phases; ph++) begin
			p0 = pick_period();
			p1 = pick_period();
			cap = CREDIT_W'($urandom_range(7));
			if (ph == 0) begin
				p0 = 16'd0;
				p1 = 16'hFFFE;
				cap = 3'd7;
			end else if (ph == 1) begin
				p0 = 16'hFFFF;
				p1 = 16'd0;
				cap = 3'd0;
			end else if (ph == 2) begin
				cap = 3'd1;
			end
			write_settings(p0, p1, cap);
			for (int n = 0; n < per_phase; n++) begin
				roll = $urandom_range(99);
				if (roll < 55)
					send_op(OP_TICK, 1'($urandom_range(1)));
				else if (roll < 75)
					send_op(OP_PET, 1'($urandom_range(1)));
				else if (roll < 85)
					send_op(OP_EXPIRE, 1'($urandom_range(1)));
				else
					send_op(OP_UNUSED, 1'($urandom_range(1)));
				// occasional pause until the pipeline is empty
				if ($urandom_range(99) < 3)
					await_results();
			end
			await_results();
		end
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure(input int count);
		idle_on <= 1'b0;
		stall_orders <= stall_orders + 1;
		for (int n = 0; n < count; n++)
			send_op(OP_TICK + OP_W'($urandom_range(3)), 1'($urandom_range(1)));
		await_results();
		idle_on <= 1'b1;
	endtask

	// long stretch with no idling on either side
	task automatic test_back_to_back(input int count);
		write_settings(CFG_W'($urandom_range(3)), CFG_W'($urandom_range(3)),
			CREDIT_W'($urandom_range(1, 7)));
		idle_on <= 1'b0;
		for (int n = 0; n < count; n++)
			send_op(OP_W'($urandom_range(3)), 1'($urandom_range(1)));
		await_results();
		idle_on <= 1'b1;
	endtask

	initial begin
		clear_mirror();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_operations();
		test_limit_edges();
		test_random_traffic(13, 100);
		test_backpressure(80);
		test_back_to_back(250);

		await_results();
		repeat (10) @(posedge clk);
		$display("covered %0d operations over %0d register settings, %0d statuses checked",
			ops_sent, settings_used, verdicts_checked);
		$display("timeouts reported: %0d, including stall and back-to-back phases",
			timeouts_seen);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
